@@ hw/rtl/lscm_triangle_row_builder_core_defines.svh @@
// Assertion macros for the triangle row builder.
`ifndef LSCM_TRIANGLE_ROW_BUILDER_CORE_DEFINES_SVH
`define LSCM_TRIANGLE_ROW_BUILDER_CORE_DEFINES_SVH
`define LTRB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LTRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hw/rtl/ltrb_pkg.sv @@
// Shared types and constants of the triangle row builder.
package ltrb_pkg;
    localparam int IdxW = 16;
    localparam int IdW = 17;
    localparam int CoefW = 32;
    localparam int EdgeW = 33;
    localparam int SqW = 68;
    localparam int CrW = 67;
    localparam int CmW = 66;
    localparam int LoW = 32;
    localparam int CrSqW = 136;
    localparam int RootW = 68;
    localparam int QW = 136;
    localparam int SqrtSteps = 68;
    localparam int DivSteps = 136;
    localparam logic [16:0] MaxVertices = 17'd65536;
    localparam int DepthFront = 4;

    typedef struct packed {
        logic [IdxW-1:0] i0;
        logic [IdxW-1:0] i1;
        logic [IdxW-1:0] i2;
        logic            bad_idx;
    } tag_t;

    function automatic logic [CoefW-1:0] sat_coef(input logic signed [QW+1:0] v);
        logic signed [QW+1:0] mx;
        logic signed [QW+1:0] mn;
        begin
            mx = (QW+2)'(32'sh7fffffff);
            mn = -(QW+2)'(64'sh80000000);
            if (v > mx)
                sat_coef = 32'h7fffffff;
            else if (v < mn)
                sat_coef = 32'h80000000;
            else
                sat_coef = v[CoefW-1:0];
        end
    endfunction
endpackage

@@ hw/rtl/ltrb_geom.sv @@
// Geometry stages: edges, products, sums of squares, dot product and squared cross product.
module ltrb_geom
    import ltrb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  tag_t                    in_tag,
    input  logic signed [31:0]      p0 [3],
    input  logic signed [31:0]      p1 [3],
    input  logic signed [31:0]      p2 [3],
    output logic                    out_valid,
    output tag_t                    out_tag,
    output logic [SqW+1:0]          s1,
    output logic signed [SqW+1:0]   dot,
    output logic [CrSqW-1:0]        sc
);
    logic                      v_reg [7];
    tag_t                      t_reg [7];
    logic signed [EdgeW-1:0]   e1_reg [3];
    logic signed [EdgeW-1:0]   e2_reg [3];
    logic signed [SqW-1:0]     sq_reg [3];
    logic signed [SqW-1:0]     dp_reg [3];
    logic signed [SqW-1:0]     cp_reg [6];
    logic [SqW+1:0]            s1_reg;
    logic signed [SqW+1:0]     dot_reg;
    logic [SqW+1:0]            s1d_reg [4];
    logic signed [SqW+1:0]     dotd_reg [4];
    logic signed [CrW-1:0]     cr_reg [3];
    logic [CmW-1:0]            cm_reg [3];
    logic [2*(CmW-LoW)-1:0]    hh_reg [3];
    logic [CmW-1:0]            hl_reg [3];
    logic [2*LoW-1:0]          ll_reg [3];
    logic [CrSqW-1:0]          csq_reg [3];
    logic [CrSqW-1:0]          sc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 7; k++)
                v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < 7; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0] <= in_tag;
            for (int k = 1; k < 7; k++)
                t_reg[k] <= t_reg[k-1];
            for (int k = 0; k < 3; k++)
            begin
                e1_reg[k] <= EdgeW'(p1[k]) - EdgeW'(p0[k]);
                e2_reg[k] <= EdgeW'(p2[k]) - EdgeW'(p0[k]);
                sq_reg[k] <= SqW'(e1_reg[k]) * SqW'(e1_reg[k]);
                dp_reg[k] <= SqW'(e1_reg[k]) * SqW'(e2_reg[k]);
            end
            cp_reg[0] <= SqW'(e1_reg[1]) * SqW'(e2_reg[2]);
            cp_reg[1] <= SqW'(e1_reg[2]) * SqW'(e2_reg[1]);
            cp_reg[2] <= SqW'(e1_reg[2]) * SqW'(e2_reg[0]);
            cp_reg[3] <= SqW'(e1_reg[0]) * SqW'(e2_reg[2]);
            cp_reg[4] <= SqW'(e1_reg[0]) * SqW'(e2_reg[1]);
            cp_reg[5] <= SqW'(e1_reg[1]) * SqW'(e2_reg[0]);
            s1_reg  <= (SqW+2)'(unsigned'(sq_reg[0])) + (SqW+2)'(unsigned'(sq_reg[1]))
                     + (SqW+2)'(unsigned'(sq_reg[2]));
            dot_reg <= (SqW+2)'(dp_reg[0]) + (SqW+2)'(dp_reg[1]) + (SqW+2)'(dp_reg[2]);
            cr_reg[0] <= CrW'(cp_reg[0]) - CrW'(cp_reg[1]);
            cr_reg[1] <= CrW'(cp_reg[2]) - CrW'(cp_reg[3]);
            cr_reg[2] <= CrW'(cp_reg[4]) - CrW'(cp_reg[5]);
            s1d_reg[0]  <= s1_reg;
            dotd_reg[0] <= dot_reg;
            for (int k = 1; k < 4; k++)
            begin
                s1d_reg[k]  <= s1d_reg[k-1];
                dotd_reg[k] <= dotd_reg[k-1];
            end
            // cross terms squared as high and low halves
            for (int k = 0; k < 3; k++)
            begin
                cm_reg[k] <= cr_reg[k][CrW-1] ? CmW'(-cr_reg[k]) : CmW'(cr_reg[k]);
                hh_reg[k] <= (2*(CmW-LoW))'(cm_reg[k][CmW-1:LoW])
                           * (2*(CmW-LoW))'(cm_reg[k][CmW-1:LoW]);
                hl_reg[k] <= CmW'(cm_reg[k][CmW-1:LoW]) * CmW'(cm_reg[k][LoW-1:0]);
                ll_reg[k] <= (2*LoW)'(cm_reg[k][LoW-1:0]) * (2*LoW)'(cm_reg[k][LoW-1:0]);
                csq_reg[k] <= (CrSqW'(hh_reg[k]) << (2*LoW))
                            + (CrSqW'(hl_reg[k]) << (LoW+1))
                            + CrSqW'(ll_reg[k]);
            end
            sc_reg <= csq_reg[0] + csq_reg[1] + csq_reg[2];
        end
    end

    assign out_valid = v_reg[6];
    assign out_tag   = t_reg[6];
    assign s1        = s1d_reg[3];
    assign dot       = dotd_reg[3];
    assign sc        = sc_reg;
endmodule

@@ hw/rtl/ltrb_solve.sv @@
// Square root and division pipeline, one result bit per stage.
module ltrb_solve
    import ltrb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  tag_t                   in_tag,
    input  logic [SqW+1:0]         s1,
    input  logic signed [SqW+1:0]  dot,
    input  logic [CrSqW-1:0]       sc,
    output logic                   out_valid,
    output tag_t                   out_tag,
    output logic                   degen,
    output logic [QW-1:0]          a,
    output logic signed [QW+1:0]   c,
    output logic [QW-1:0]          d
);
    // phase 1: both roots, bit-serial restoring, one bit per stage
    localparam int NR = SqrtSteps;
    localparam int RW = CrSqW + 2;
    logic              rv_reg [NR+1];
    tag_t              rt_reg [NR+1];
    logic [RW-1:0]     rrem1_reg [NR+1], rrem2_reg [NR+1];
    logic [RootW-1:0]  rq1_reg [NR+1], rq2_reg [NR+1];
    logic [CrSqW-1:0]  rn1_reg [NR+1], rn2_reg [NR+1];
    logic              rneg_reg [NR+1];
    logic [SqW+1:0]    rdot_reg [NR+1];

    always_comb
    begin
        rv_reg[0]    = in_valid;
        rt_reg[0]    = in_tag;
        rrem1_reg[0] = '0;
        rrem2_reg[0] = '0;
        rq1_reg[0]   = '0;
        rq2_reg[0]   = '0;
        rn1_reg[0]   = CrSqW'(s1);
        rn2_reg[0]   = sc;
        rneg_reg[0]  = dot[SqW+1];
        rdot_reg[0]  = dot[SqW+1] ? unsigned'(-dot) : unsigned'(dot);
    end

    for (genvar g = 0; g < NR; g++) begin : g_root
        logic [RW-1:0] r1, r2, t1, t2;
        always_comb
        begin
            r1 = {rrem1_reg[g][RW-3:0], rn1_reg[g][CrSqW-1 -: 2]};
            r2 = {rrem2_reg[g][RW-3:0], rn2_reg[g][CrSqW-1 -: 2]};
            t1 = RW'({rq1_reg[g], 2'b01});
            t2 = RW'({rq2_reg[g], 2'b01});
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rv_reg[g+1] <= 1'b0;
            else if (en)
                rv_reg[g+1] <= rv_reg[g];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_reg[g+1]   <= rt_reg[g];
                rn1_reg[g+1]  <= rn1_reg[g] << 2;
                rn2_reg[g+1]  <= rn2_reg[g] << 2;
                rneg_reg[g+1] <= rneg_reg[g];
                rdot_reg[g+1] <= rdot_reg[g];
                if (r1 >= t1)
                begin
                    rrem1_reg[g+1] <= r1 - t1;
                    rq1_reg[g+1]   <= {rq1_reg[g][RootW-2:0], 1'b1};
                end
                else
                begin
                    rrem1_reg[g+1] <= r1;
                    rq1_reg[g+1]   <= {rq1_reg[g][RootW-2:0], 1'b0};
                end
                if (r2 >= t2)
                begin
                    rrem2_reg[g+1] <= r2 - t2;
                    rq2_reg[g+1]   <= {rq2_reg[g][RootW-2:0], 1'b1};
                end
                else
                begin
                    rrem2_reg[g+1] <= r2;
                    rq2_reg[g+1]   <= {rq2_reg[g][RootW-2:0], 1'b0};
                end
            end
        end
    end

    // phase 2: |dot|/a and root2/a, restoring, one bit per stage
    localparam int ND = SqW + 2;
    localparam int DW = RootW + 1;
    logic              dv_reg [ND+1];
    tag_t              dt_reg [ND+1];
    logic [RootW-1:0]  da_reg [ND+1];
    logic [DW-1:0]     drc_reg [ND+1], drd_reg [ND+1];
    logic [ND-1:0]     dnc_reg [ND+1], dqc_reg [ND+1];
    logic [ND-1:0]     dnd_reg [ND+1], dqd_reg [ND+1];
    logic              dneg_reg [ND+1];

    always_comb
    begin
        dv_reg[0]   = rv_reg[NR];
        dt_reg[0]   = rt_reg[NR];
        da_reg[0]   = rq1_reg[NR];
        drc_reg[0]  = '0;
        drd_reg[0]  = '0;
        dnc_reg[0]  = rdot_reg[NR];
        dnd_reg[0]  = ND'(rq2_reg[NR]);
        dqc_reg[0]  = '0;
        dqd_reg[0]  = '0;
        dneg_reg[0] = rneg_reg[NR];
    end

    for (genvar g = 0; g < ND; g++) begin : g_div
        logic [DW-1:0] xc, xd, dv;
        always_comb
        begin
            xc = {drc_reg[g][DW-2:0], dnc_reg[g][ND-1]};
            xd = {drd_reg[g][DW-2:0], dnd_reg[g][ND-1]};
            dv = DW'(da_reg[g]);
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[g+1] <= 1'b0;
            else if (en)
                dv_reg[g+1] <= dv_reg[g];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dt_reg[g+1]   <= dt_reg[g];
                da_reg[g+1]   <= da_reg[g];
                dneg_reg[g+1] <= dneg_reg[g];
                dnc_reg[g+1]  <= dnc_reg[g] << 1;
                dnd_reg[g+1]  <= dnd_reg[g] << 1;
                if (xc >= dv && dv != '0)
                begin
                    drc_reg[g+1] <= xc - dv;
                    dqc_reg[g+1] <= {dqc_reg[g][ND-2:0], 1'b1};
                end
                else
                begin
                    drc_reg[g+1] <= xc;
                    dqc_reg[g+1] <= {dqc_reg[g][ND-2:0], 1'b0};
                end
                if (xd >= dv && dv != '0)
                begin
                    drd_reg[g+1] <= xd - dv;
                    dqd_reg[g+1] <= {dqd_reg[g][ND-2:0], 1'b1};
                end
                else
                begin
                    drd_reg[g+1] <= xd;
                    dqd_reg[g+1] <= {dqd_reg[g][ND-2:0], 1'b0};
                end
            end
        end
    end

    logic bad;
    logic signed [QW+1:0] cs;
    always_comb
    begin
        bad = (da_reg[ND] == '0) || (dqd_reg[ND] == '0) || dt_reg[ND].bad_idx;
        cs  = dneg_reg[ND] ? -(QW+2)'(dqc_reg[ND]) : (QW+2)'(dqc_reg[ND]);
    end

    assign out_valid = dv_reg[ND];
    assign out_tag   = dt_reg[ND];
    assign degen     = bad;
    assign a         = bad ? '0 : QW'(da_reg[ND]);
    assign c         = bad ? '0 : cs;
    assign d         = bad ? '0 : QW'(dqd_reg[ND]);
endmodule

@@ hw/rtl/ltrb_rows.sv @@
// Output stage: holds one triangle and sends its two rows.
module ltrb_rows
    import ltrb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tag_t                  in_tag,
    input  logic                  in_degen,
    input  logic [QW-1:0]         in_a,
    input  logic signed [QW+1:0]  in_c,
    input  logic [QW-1:0]         in_d,
    output logic                  valid,
    input  logic                  ready,
    output logic                  row_last,
    output logic                  degenerate,
    output logic [IdW-1:0]        id_u0,
    output logic [CoefW-1:0]      coef_u0,
    output logic [IdW-1:0]        id_v0,
    output logic [CoefW-1:0]      coef_v0,
    output logic [IdW-1:0]        id_u1,
    output logic [CoefW-1:0]      coef_u1,
    output logic [IdW-1:0]        id_v1,
    output logic [CoefW-1:0]      coef_v1,
    output logic [IdW-1:0]        id_third,
    output logic [CoefW-1:0]      coef_third
);
    logic                 full_reg, row_reg;
    tag_t                 tag_reg;
    logic                 dg_reg;
    logic [CoefW-1:0]     cma_reg, nd_reg, nc_reg, d_reg, a_reg;
    logic                 take;

    assign in_ready = !full_reg || (row_reg && ready);
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            row_reg  <= 1'b0;
        end
        else if (take)
        begin
            full_reg <= 1'b1;
            row_reg  <= 1'b0;
        end
        else if (full_reg && ready)
        begin
            if (row_reg)
                full_reg <= 1'b0;
            row_reg <= !row_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tag_reg <= in_tag;
            dg_reg  <= in_degen;
            cma_reg <= sat_coef(in_c - (QW+2)'(in_a));
            nd_reg  <= sat_coef(-(QW+2)'(in_d));
            nc_reg  <= sat_coef(-in_c);
            d_reg   <= sat_coef((QW+2)'(in_d));
            a_reg   <= sat_coef((QW+2)'(in_a));
        end
    end

    assign valid      = full_reg;
    assign row_last   = row_reg;
    assign degenerate = dg_reg;
    assign id_u0      = {tag_reg.i0, 1'b0};
    assign id_v0      = {tag_reg.i0, 1'b1};
    assign id_u1      = {tag_reg.i1, 1'b0};
    assign id_v1      = {tag_reg.i1, 1'b1};
    assign id_third   = {tag_reg.i2, row_reg};
    assign coef_u0    = row_reg ? d_reg : cma_reg;
    assign coef_v0    = row_reg ? cma_reg : nd_reg;
    assign coef_u1    = row_reg ? nd_reg : nc_reg;
    assign coef_v1    = row_reg ? nc_reg : d_reg;
    assign coef_third = a_reg;
endmodule

@@ hw/rtl/lscm_triangle_row_builder_core.sv @@
// Top level of the triangle row builder.
//  channel | signals                         | dir
//  input   | in_valid/in_ready + 12 fields   | in
//  output  | valid/ready + 12 fields         | out
// The first row is valid after 7 geometry, 68 root and 70 divide stages
// and the row register; the second row follows once the first is taken.
// One triangle enters per cycle while the pipeline moves; rows leave one per
// cycle while ready is high; the row stage, with two rows per triangle,
// sets the steady rate. The pipeline stalls as a whole when the row stage
// cannot take its item. Reset clears the valid bits and the row flag only.
`include "lscm_triangle_row_builder_core_defines.svh"
module lscm_triangle_row_builder_core
    import ltrb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [IdxW-1:0]         vertex0_index,
    input  logic [IdxW-1:0]         vertex1_index,
    input  logic [IdxW-1:0]         vertex2_index,
    input  logic signed [31:0]      p0_x,
    input  logic signed [31:0]      p0_y,
    input  logic signed [31:0]      p0_z,
    input  logic signed [31:0]      p1_x,
    input  logic signed [31:0]      p1_y,
    input  logic signed [31:0]      p1_z,
    input  logic signed [31:0]      p2_x,
    input  logic signed [31:0]      p2_y,
    input  logic signed [31:0]      p2_z,
    output logic                    valid,
    input  logic                    ready,
    output logic                    row_last,
    output logic                    degenerate,
    output logic [IdW-1:0]          id_u0,
    output logic signed [CoefW-1:0] coef_u0,
    output logic [IdW-1:0]          id_v0,
    output logic signed [CoefW-1:0] coef_v0,
    output logic [IdW-1:0]          id_u1,
    output logic signed [CoefW-1:0] coef_u1,
    output logic [IdW-1:0]          id_v1,
    output logic signed [CoefW-1:0] coef_v1,
    output logic [IdW-1:0]          id_third,
    output logic signed [CoefW-1:0] coef_third
);
    logic en, sv, gv, rows_ready;
    tag_t tin, gt, st;
    logic signed [31:0] p0 [3], p1 [3], p2 [3];
    logic [SqW+1:0] s1;
    logic signed [SqW+1:0] dot;
    logic [CrSqW-1:0] sc;
    logic dg;
    logic [QW-1:0] a, d;
    logic signed [QW+1:0] c;

    assign en       = !sv || rows_ready;
    assign in_ready = en;
    assign tin.i0 = vertex0_index;
    assign tin.i1 = vertex1_index;
    assign tin.i2 = vertex2_index;
    assign tin.bad_idx = (17'(vertex0_index) >= MaxVertices)
                      || (17'(vertex1_index) >= MaxVertices)
                      || (17'(vertex2_index) >= MaxVertices);
    assign p0 = '{p0_x, p0_y, p0_z};
    assign p1 = '{p1_x, p1_y, p1_z};
    assign p2 = '{p2_x, p2_y, p2_z};

    ltrb_geom u_geom (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid), .in_tag(tin),
        .p0(p0), .p1(p1), .p2(p2),
        .out_valid(gv), .out_tag(gt), .s1(s1), .dot(dot), .sc(sc)
    );

    ltrb_solve u_solve (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(gv), .in_tag(gt),
        .s1(s1), .dot(dot), .sc(sc),
        .out_valid(sv), .out_tag(st), .degen(dg), .a(a), .c(c), .d(d)
    );

    ltrb_rows u_rows (
        .clk(clk), .rst_n(rst_n), .in_valid(sv), .in_ready(rows_ready),
        .in_tag(st), .in_degen(dg), .in_a(a), .in_c(c), .in_d(d),
        .valid(valid), .ready(ready), .row_last(row_last), .degenerate(degenerate),
        .id_u0(id_u0), .coef_u0(coef_u0), .id_v0(id_v0), .coef_v0(coef_v0),
        .id_u1(id_u1), .coef_u1(coef_u1), .id_v1(id_v1), .coef_v1(coef_v1),
        .id_third(id_third), .coef_third(coef_third)
    );

    `LTRB_ASSERT_NEXT(a_row_order, valid && ready && !row_last, valid && row_last,
        "imaginary row must follow real row")
    `LTRB_ASSERT_IMPL(a_degen_zero, valid && degenerate, coef_third == '0,
        "degenerate triangle with nonzero edge")
    `LTRB_ASSERT_IMPL(a_third_id, valid, id_third[0] == row_last,
        "third id does not match row")
endmodule
